// ----- rtl/core/mpq_pkg.sv -----
// shared types and constants for the unsorted max-priority queue
package mpq_pkg;

  localparam int unsigned CapacityDef = 64;
  localparam int unsigned PrioW       = 32;
  localparam int unsigned PayloadW    = 32;

  typedef enum logic [1:0] {
    StatusEnq     = 2'd0,
    StatusDeq     = 2'd1,
    StatusEmpty   = 2'd2,
    StatusDropped = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    OpEnqueue = 1'b0,
    OpDequeue = 1'b1
  } op_e;

  typedef struct packed {
    logic signed [PrioW-1:0] prio;
    logic [PayloadW-1:0]     payload;
  } entry_t;

  // scan token handed from cell to cell during a dequeue
  typedef struct packed {
    logic   vld;
    logic   found;
    entry_t best;
    entry_t last;
  } scan_t;

endpackage

// ----- rtl/core/mpq_cell.sv -----
// one table slot of the queue with its stage of the dequeue scan
module mpq_cell import mpq_pkg::*; #(
  parameter int unsigned CAPACITY = CapacityDef,
  parameter int unsigned SLOT     = 0,
  localparam int unsigned IW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [CW-1:0] count_i,
  input  scan_t         tok_i,
  input  logic [IW-1:0] idx_i,
  output scan_t         tok_o,
  output logic [IW-1:0] idx_o,
  input  logic          wr_en_i,
  input  logic [IW-1:0] wr_idx_i,
  input  entry_t        wr_entry_i
);

  localparam logic [CW-1:0] SlotC = CW'(SLOT);
  localparam logic [IW-1:0] SlotI = IW'(SLOT);

  entry_t        entry_q;
  scan_t         tok_d;
  logic          vld_q, found_q;
  entry_t        best_q, last_q;
  logic [IW-1:0] idx_d, idx_q;
  logic          active, take;

  assign active = tok_i.vld && (SlotC < count_i);
  assign take   = active && (!tok_i.found || (entry_q.prio > tok_i.best.prio));

  always_comb begin
    tok_d = tok_i;
    idx_d = idx_i;
    if (take) begin
      tok_d.found = 1'b1;
      tok_d.best  = entry_q;
      idx_d       = SlotI;
    end
    // the last occupied slot hands its entry along to refill the freed one
    if (active && (SlotC == count_i - CW'(1))) begin
      tok_d.last = entry_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= tok_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= tok_d.found;
    best_q  <= tok_d.best;
    last_q  <= tok_d.last;
    idx_q   <= idx_d;
    if (wr_en_i && (wr_idx_i == SlotI)) begin
      entry_q <= wr_entry_i;
    end
  end

  assign tok_o = scan_t'{vld: vld_q, found: found_q, best: best_q, last: last_q};
  assign idx_o = idx_q;

endmodule

// ----- rtl/core/max_priority_queue_unsorted.sv -----
// top level of the unsorted max-priority queue built as a row of slot cells
//
// Input channel (in_valid_i / in_ready_o) takes one word: operation_i, prio_i,
// payload_i. Output channel (out_valid_o / out_ready_i) returns one word per
// input word: status_o, payload_out_o, now_empty_o.
// Enqueue writes the word into the slot after the last entry; its result is
// registered and shows in the cycle after acceptance. An enqueue into a full
// table is dropped with status 3, a dequeue of an empty table returns status 2,
// both also registered and shown in the cycle after acceptance.
// A dequeue sends a scan token along the row of CAPACITY cells, one cell per
// cycle, through each cell's token register in turn; the result is registered
// after the last cell. At the end the winning slot is refilled from the
// last occupied slot. Ties go to the lowest slot.
// One word is in flight at a time. The next word is taken once the previous
// result has left the output register or is taken in the same cycle, so a
// dequeue occupies the block until its scan has finished. A stalled receiver
// holds the result in the output register and holds off the input side.
// Reset empties the table; no clearing pass is needed.
module max_priority_queue_unsorted import mpq_pkg::*; #(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                operation_i,
  input  logic signed [31:0]  prio_i,
  input  logic [31:0]         payload_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic [31:0]         payload_out_o,
  output logic                now_empty_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StScan = 2'b10
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          out_valid_q, out_valid_d;
  status_e       status_q, status_d;
  logic [31:0]   payload_out_q, payload_out_d;
  logic          now_empty_q, now_empty_d;

  scan_t         tok_chain [CAPACITY+1];
  logic [IW-1:0] idx_chain [CAPACITY+1];

  logic          accept, is_deq, finish, enq_ok;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  entry_t        wr_entry;

  assign in_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign is_deq     = (op_e'(operation_i) == OpDequeue);
  assign enq_ok     = accept && !is_deq && (count_q < CapC);
  assign finish     = tok_chain[CAPACITY].vld;

  // seed token enters the first cell on a dequeue of a non-empty table
  assign tok_chain[0] = scan_t'{vld: accept && is_deq && (count_q != '0),
                                found: 1'b0, best: '0, last: '0};
  assign idx_chain[0] = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    mpq_cell #(
      .CAPACITY(CAPACITY),
      .SLOT    (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .count_i   (count_q),
      .tok_i     (tok_chain[g]),
      .idx_i     (idx_chain[g]),
      .tok_o     (tok_chain[g+1]),
      .idx_o     (idx_chain[g+1]),
      .wr_en_i   (wr_en),
      .wr_idx_i  (wr_idx),
      .wr_entry_i(wr_entry)
    );
  end

  always_comb begin
    wr_en    = enq_ok || finish;
    wr_idx   = finish ? idx_chain[CAPACITY] : count_q[IW-1:0];
    wr_entry = finish ? tok_chain[CAPACITY].last : entry_t'{prio: prio_i, payload: payload_i};
  end

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    status_d      = status_q;
    payload_out_d = payload_out_q;
    now_empty_d   = now_empty_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          payload_out_d = '0;
          if (!is_deq) begin
            out_valid_d = 1'b1;
            now_empty_d = 1'b0;
            if (count_q < CapC) begin
              status_d = StatusEnq;
              count_d  = count_q + CW'(1);
            end else begin
              status_d = StatusDropped;
            end
          end else if (count_q == '0) begin
            out_valid_d = 1'b1;
            status_d    = StatusEmpty;
            now_empty_d = 1'b1;
          end else begin
            state_d = StScan;
          end
        end
      end
      StScan: begin
        if (finish) begin
          state_d       = StIdle;
          count_d       = count_q - CW'(1);
          out_valid_d   = 1'b1;
          status_d      = StatusDeq;
          payload_out_d = tok_chain[CAPACITY].best.payload;
          now_empty_d   = (count_q == CW'(1));
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q      <= status_d;
    payload_out_q <= payload_out_d;
    now_empty_q   <= now_empty_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign payload_out_o = payload_out_q;
  assign now_empty_o   = now_empty_q;

endmodule

// ----- rtl/core/mpq_checker.sv -----
// port-level checks for the unsorted max-priority queue, bound to the top level
module mpq_assert import mpq_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [31:0] payload_out_o,
  input logic        now_empty_o
);

  // a waiting result word stays put until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(payload_out_o) && $stable(now_empty_o))
    else $error("result word changed while stalled");

  // an enqueue or a dropped enqueue never leaves the table empty
  a_enq_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StatusEnq || status_o == StatusDropped) |->
    !now_empty_o && (payload_out_o == '0))
    else $error("enqueue result reports empty table or payload");

  // dequeue of an empty table reports empty with zero payload
  a_empty_deq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StatusEmpty) |-> now_empty_o && (payload_out_o == '0))
    else $error("empty dequeue result malformed");

  // a pending result blocks new words unless it is being taken
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result word stalled");

endmodule

bind max_priority_queue_unsorted mpq_assert u_mpq_assert (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .payload_out_o(payload_out_o),
  .now_empty_o  (now_empty_o)
);
